[design/wpgb_pkg.sv]
// Package for the weighted particle grid binning block.
// Holds the request codes, register indexes and field widths; no dependencies.
`default_nettype none

package wpgb_pkg;

  localparam int REQ_W   = 2;
  localparam int CFG_W   = 2;
  localparam int DATA_W  = 24;
  localparam int POS_W   = 24;
  localparam int WGT_W   = 16;
  localparam int SIZE_W  = 16;
  localparam int SIDE_W  = 8;
  localparam int COORD_W = 7;
  localparam int SUM_W   = 24;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ACCUM = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_GRID_SIDE = 2'd0,
    CFG_BIN_SIZE  = 2'd1,
    CFG_CENTER_X  = 2'd2,
    CFG_CENTER_Y  = 2'd3
  } cfg_e;

endpackage

`default_nettype wire

[design/wpgb_ram.sv]
// Generic single-port RAM with registered read data.
// Width and depth are parameters; no dependencies.
`default_nettype none

module wpgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[design/weighted_particle_grid_binning.sv]
// Top level of the weighted particle grid binning block.
// Depends on wpgb_pkg and on wpgb_ram for the bin storage.
//
// Requests enter on the input channel (in_valid_i, in_stall_o) and each one
// gives exactly one result on the output channel (out_valid_o, out_stall_i).
// A request is taken when valid is high and stall is low. Registers are
// written through the configuration channel (cfg_valid_i, cfg_ready_o); the
// user must write them only while the block is idle, which the block itself
// does not enforce; cfg_ready_o is always high. The block works on one
// request at a time and stalls its input meanwhile. An accumulate request
// passes through the shared restoring divider, which runs one quotient bit
// per cycle for each axis in turn. A clear request sweeps the bin memory one
// entry per cycle. After reset the same sweep clears the memory with the
// input stalled and no result given.
// A finished result sits in the output register while the receiver stalls;
// the next request is taken meanwhile and waits for the register to free up.
`default_nettype none

module weighted_particle_grid_binning #(
  parameter int GRID_MAX_SIDE = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wpgb_pkg::CFG_W-1:0]     cfg_index_i,
  input  wire logic [wpgb_pkg::DATA_W-1:0]    cfg_data_i,

  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [wpgb_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic                           is_particle_i,
  input  wire logic signed [wpgb_pkg::POS_W-1:0] pos_x_i,
  input  wire logic signed [wpgb_pkg::POS_W-1:0] pos_y_i,
  input  wire logic [wpgb_pkg::WGT_W-1:0]     weight_i,
  input  wire logic [wpgb_pkg::COORD_W-1:0]   read_col_i,
  input  wire logic [wpgb_pkg::COORD_W-1:0]   read_row_i,

  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                in_range_o,
  output logic [wpgb_pkg::SUM_W-1:0]          bin_value_o,
  output logic [wpgb_pkg::SUM_W-1:0]          peak_value_o,
  output logic [wpgb_pkg::COORD_W-1:0]        min_col_o,
  output logic [wpgb_pkg::COORD_W-1:0]        max_col_o,
  output logic [wpgb_pkg::COORD_W-1:0]        min_row_o,
  output logic [wpgb_pkg::COORD_W-1:0]        max_row_o
);

  import wpgb_pkg::*;

  localparam int IW    = $clog2(GRID_MAX_SIDE);
  localparam int SW    = $clog2(GRID_MAX_SIDE + 1);
  localparam int XW    = (SW > SIDE_W) ? SW : SIDE_W;
  localparam int CW    = (SW > COORD_W) ? SW : COORD_W;
  localparam int DEPTH = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = SW + SIZE_W;
  localparam int VW    = ((PW > POS_W + 1) ? PW : POS_W + 1) + 2;
  localparam int CNW   = (IW > 1) ? $clog2(IW) : 1;
  localparam int RST_SIDE = (64 > GRID_MAX_SIDE) ? GRID_MAX_SIDE : 64;
  localparam int BOX_RST  = RST_SIDE / 2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_OFF,
    S_DIV,
    S_ADDR,
    S_RD,
    S_UPD,
    S_DONE
  } state_e;

  state_e state_q;

  logic [SIDE_W-1:0]       grid_side_q;
  logic [SIZE_W-1:0]       bin_size_q;
  logic signed [POS_W-1:0] center_x_q;
  logic signed [POS_W-1:0] center_y_q;

  req_e                    req_q;
  logic signed [POS_W-1:0] pos_x_q;
  logic signed [POS_W-1:0] pos_y_q;
  logic [WGT_W-1:0]        weight_q;

  logic [PW-1:0]  half_q;
  logic [PW-1:0]  lim_q;
  logic           axis_q;
  logic [PW-1:0]  rem_q;
  logic [PW-1:0]  dvs_q;
  logic [IW-1:0]  quo_q;
  logic [CNW-1:0] cnt_q;
  logic [IW-1:0]  col_q;
  logic [IW-1:0]  row_q;
  logic [AW-1:0]  addr_q;
  logic           emit_q;

  logic [SUM_W-1:0] peak_q;
  logic [IW-1:0]    box_min_col_q;
  logic [IW-1:0]    box_max_col_q;
  logic [IW-1:0]    box_min_row_q;
  logic [IW-1:0]    box_max_row_q;

  logic             res_range_q;
  logic [SUM_W-1:0] res_value_q;

  logic             out_valid_q;
  logic             out_range_q;
  logic [SUM_W-1:0] out_value_q;
  logic [SUM_W-1:0] out_peak_q;
  logic [COORD_W-1:0] out_min_col_q;
  logic [COORD_W-1:0] out_max_col_q;
  logic [COORD_W-1:0] out_min_row_q;
  logic [COORD_W-1:0] out_max_row_q;

  logic [SW-1:0]     side_use;
  logic [SIZE_W-1:0] size_use;
  logic signed [VW-1:0] pos_e;
  logic signed [VW-1:0] cen_e;
  logic signed [VW-1:0] half_e;
  logic signed [VW-1:0] lim_e;
  logic signed [VW-1:0] v;
  logic              ge;
  logic [PW-1:0]     rem_d;
  logic [IW-1:0]     quo_d;
  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_d;
  logic              rd_ok;
  logic              out_free;
  logic              in_acc;

  logic             ram_we;
  logic [SUM_W-1:0] ram_wdata;
  logic [SUM_W-1:0] ram_rdata;

  always_comb begin
    if (grid_side_q < SIDE_W'(2)) begin
      side_use = SW'(2);
    end else if (XW'(grid_side_q) > XW'(GRID_MAX_SIDE)) begin
      side_use = SW'(GRID_MAX_SIDE);
    end else begin
      side_use = SW'(grid_side_q);
    end
  end

  assign size_use = (bin_size_q == '0) ? SIZE_W'(1) : bin_size_q;

  assign pos_e  = axis_q ? VW'(pos_y_q) : VW'(pos_x_q);
  assign cen_e  = axis_q ? VW'(center_y_q) : VW'(center_x_q);
  assign half_e = VW'(half_q);
  assign lim_e  = VW'(lim_q);
  assign v      = pos_e - cen_e + half_e;

  assign ge    = (rem_q >= dvs_q);
  assign rem_d = ge ? (rem_q - dvs_q) : rem_q;
  assign quo_d = IW'({quo_q, ge});

  assign sum_raw = {1'b0, ram_rdata} + (SUM_W + 1)'(weight_q);
  assign sum_d   = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];

  assign rd_ok = (CW'(read_col_i) < CW'(side_use)) && (CW'(read_row_i) < CW'(side_use));

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_UPD) && (req_q == REQ_ACCUM));
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : sum_d;

  wpgb_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (addr_q),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= SIDE_W'(64);
      bin_size_q  <= SIZE_W'(100);
      center_x_q  <= '0;
      center_y_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_e'(cfg_index_i))
        CFG_GRID_SIDE: grid_side_q <= cfg_data_i[SIDE_W-1:0];
        CFG_BIN_SIZE:  bin_size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_CENTER_X:  center_x_q  <= cfg_data_i;
        CFG_CENTER_Y:  center_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      req_q         <= REQ_NONE;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      weight_q      <= '0;
      half_q        <= '0;
      lim_q         <= '0;
      axis_q        <= 1'b0;
      rem_q         <= '0;
      dvs_q         <= '0;
      quo_q         <= '0;
      cnt_q         <= '0;
      col_q         <= '0;
      row_q         <= '0;
      addr_q        <= '0;
      emit_q        <= 1'b0;
      peak_q        <= '0;
      box_min_col_q <= IW'(BOX_RST);
      box_max_col_q <= IW'(BOX_RST);
      box_min_row_q <= IW'(BOX_RST);
      box_max_row_q <= IW'(BOX_RST);
      res_range_q   <= 1'b0;
      res_value_q   <= '0;
      out_valid_q   <= 1'b0;
      out_range_q   <= 1'b0;
      out_value_q   <= '0;
      out_peak_q    <= '0;
      out_min_col_q <= '0;
      out_max_col_q <= '0;
      out_min_row_q <= '0;
      out_max_row_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == AW'(DEPTH - 1)) begin
            state_q <= emit_q ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            req_q       <= req_e'(req_type_i);
            pos_x_q     <= pos_x_i;
            pos_y_q     <= pos_y_i;
            weight_q    <= weight_i;
            res_range_q <= 1'b0;
            res_value_q <= '0;
            case (req_e'(req_type_i))
              REQ_CLEAR: begin
                peak_q        <= '0;
                box_min_col_q <= IW'(side_use >> 1);
                box_max_col_q <= IW'(side_use >> 1);
                box_min_row_q <= IW'(side_use >> 1);
                box_max_row_q <= IW'(side_use >> 1);
                addr_q        <= '0;
                emit_q        <= 1'b1;
                state_q       <= S_CLEAR;
              end
              REQ_ACCUM: begin
                state_q <= is_particle_i ? S_PREP : S_DONE;
              end
              REQ_READ: begin
                col_q   <= IW'(read_col_i);
                row_q   <= IW'(read_row_i);
                state_q <= rd_ok ? S_ADDR : S_DONE;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end

        S_PREP: begin
          half_q  <= PW'(side_use >> 1) * PW'(size_use);
          lim_q   <= PW'(side_use) * PW'(size_use);
          axis_q  <= 1'b0;
          state_q <= S_OFF;
        end

        S_OFF: begin
          if ((v < 0) || (v >= lim_e)) begin
            state_q <= S_DONE;
          end else begin
            rem_q   <= PW'(v);
            dvs_q   <= PW'(size_use) << (IW - 1);
            quo_q   <= '0;
            cnt_q   <= CNW'(IW - 1);
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          dvs_q <= dvs_q >> 1;
          cnt_q <= cnt_q - CNW'(1);
          if (cnt_q == '0) begin
            if (!axis_q) begin
              col_q   <= quo_d;
              axis_q  <= 1'b1;
              state_q <= S_OFF;
            end else begin
              row_q   <= quo_d;
              state_q <= S_ADDR;
            end
          end
        end

        S_ADDR: begin
          addr_q  <= AW'(row_q) * AW'(GRID_MAX_SIDE) + AW'(col_q);
          state_q <= S_RD;
        end

        S_RD: begin
          state_q <= S_UPD;
        end

        S_UPD: begin
          res_range_q <= 1'b1;
          if (req_q == REQ_ACCUM) begin
            res_value_q <= sum_d;
            if (sum_d > peak_q) begin
              peak_q <= sum_d;
            end
            if (col_q < box_min_col_q) begin
              box_min_col_q <= col_q;
            end
            if (col_q > box_max_col_q) begin
              box_max_col_q <= col_q;
            end
            if (row_q < box_min_row_q) begin
              box_min_row_q <= row_q;
            end
            if (row_q > box_max_row_q) begin
              box_max_row_q <= row_q;
            end
          end else begin
            res_value_q <= ram_rdata;
          end
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_range_q   <= res_range_q;
            out_value_q   <= res_value_q;
            out_peak_q    <= peak_q;
            out_min_col_q <= COORD_W'(box_min_col_q);
            out_max_col_q <= COORD_W'(box_max_col_q);
            out_min_row_q <= COORD_W'(box_min_row_q);
            out_max_row_q <= COORD_W'(box_max_row_q);
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign in_range_o   = out_range_q;
  assign bin_value_o  = out_value_q;
  assign peak_value_o = out_peak_q;
  assign min_col_o    = out_min_col_q;
  assign max_col_o    = out_max_col_q;
  assign min_row_o    = out_min_row_q;
  assign max_row_o    = out_max_row_q;

endmodule

`default_nettype wire
